### hdl/bvp_pkg.sv
// ----------------------------------------------------------------------------
// bvp_pkg
// Types, constants and codes for the batch vector pool.
// ----------------------------------------------------------------------------
`default_nettype none
package bvp_pkg;

  localparam int unsigned NUM_VECTORS_DEF      = 512;
  localparam int unsigned SLOTS_PER_VECTOR_DEF = 64;
  localparam int unsigned VALUE_WIDTH_DEF      = 32;

  localparam logic [2:0] OP_ADD       = 3'd0;
  localparam logic [2:0] OP_TAKE_FULL = 3'd1;
  localparam logic [2:0] OP_TAKE_OPEN = 3'd2;
  localparam logic [2:0] OP_FREE      = 3'd3;
  localparam logic [2:0] OP_READ      = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_NOTHING = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] value;
    logic [8:0]  chain_head;
    logic [8:0]  chain_tail;
    logic [9:0]  chain_count;
    logic [8:0]  read_vector;
    logic [7:0]  read_slot;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  batch_head;
    logic [8:0]  batch_tail;
    logic [9:0]  batch_count;
    logic [31:0] slot_value;
    logic [9:0]  next_link;
    logic [8:0]  fill_count;
  } out_item_t;

endpackage
`default_nettype wire

### hdl/bvp_front.sv
// ----------------------------------------------------------------------------
// bvp_front
// Input side: two-entry item queue between the port and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module bvp_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire bvp_pkg::in_item_t in_data,
  output logic                  q_valid,
  input  wire logic             q_pop,
  output bvp_pkg::in_item_t     q_data
);
  import bvp_pkg::*;

  in_item_t   mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ q_pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_data;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop of empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !q_pop) |=> cnt_r == 2'd2) else $error("full queue lost item");

endmodule
`default_nettype wire

### hdl/bvp_back.sv
// ----------------------------------------------------------------------------
// bvp_back
// Execution side: table memories, list registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module bvp_back #(
  parameter int unsigned NUM_VECTORS      = bvp_pkg::NUM_VECTORS_DEF,
  parameter int unsigned SLOTS_PER_VECTOR = bvp_pkg::SLOTS_PER_VECTOR_DEF,
  parameter int unsigned VALUE_WIDTH      = bvp_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  output logic                   q_pop,
  input  wire bvp_pkg::in_item_t q_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bvp_pkg::out_item_t     out_data
);
  import bvp_pkg::*;

  localparam int VW = $clog2(NUM_VECTORS);
  localparam int LW = VW + 1;
  localparam int SW = $clog2(SLOTS_PER_VECTOR);
  localparam int FW = $clog2(SLOTS_PER_VECTOR + 1);
  localparam int AW = VW + SW;
  localparam logic [LW-1:0] NONE = LW'(NUM_VECTORS);

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  // Link and fill tables hold their reset values after an init sweep.
  logic [LW-1:0]          link_mem [NUM_VECTORS];
  logic [FW-1:0]          fill_mem [NUM_VECTORS];
  logic [VALUE_WIDTH-1:0] val_mem  [NUM_VECTORS*SLOTS_PER_VECTOR];

  logic [1:0]    state_r, state_nxt;
  logic [VW-1:0] init_r;
  logic [LW-1:0] free_head_r, filled_head_r, filled_tail_r, filled_cnt_r, open_r;
  logic [LW-1:0] free_head_nxt, filled_head_nxt, filled_tail_nxt, filled_cnt_nxt, open_nxt;
  in_item_t      cur_r;
  logic [VW-1:0] rd_idx;
  logic [LW-1:0] link_rd_r;
  logic [FW-1:0] fill_rd_r;
  logic [VALUE_WIDTH-1:0] val_rd_r;
  logic [AW-1:0] val_raddr;
  out_item_t     res_nxt, res_r;
  logic          outv_r, outv_nxt;

  logic          lw_en, fw_en, vw_en, lw2_en;
  logic [VW-1:0] lw_a, fw_a, lw2_a;
  logic [LW-1:0] lw_d, lw2_d;
  logic [FW-1:0] fw_d;
  logic [AW-1:0] vw_a;

  logic          add_new, rd_vec_ok, rd_slot_ok;
  logic [VW-1:0] v;
  logic [FW-1:0] fill_cur, fill_new;

  assign q_pop = (state_r == S_IDLE) && q_valid && !(outv_r && !out_ready);

  // Read index chosen at pop: the vector the item touches.
  always_comb begin
    rd_idx = '0;
    if (q_data.opcode == OP_READ) begin
      rd_idx = VW'(q_data.read_vector);
    end else if (open_r == NONE) begin
      rd_idx = free_head_r[VW-1:0];
    end else begin
      rd_idx = open_r[VW-1:0];
    end
  end
  assign val_raddr = {VW'(q_data.read_vector), SW'(q_data.read_slot)};

  always_ff @(posedge clk) begin
    link_rd_r <= link_mem[rd_idx];
    fill_rd_r <= fill_mem[rd_idx];
    val_rd_r  <= val_mem[val_raddr];
    if (lw_en)  link_mem[lw_a]  <= lw_d;
    if (lw2_en) link_mem[lw2_a] <= lw2_d;
    if (fw_en)  fill_mem[fw_a]  <= fw_d;
    if (vw_en)  val_mem[vw_a]   <= cur_r.value[VALUE_WIDTH-1:0];
  end

  always_comb begin
    state_nxt       = state_r;
    free_head_nxt   = free_head_r;
    filled_head_nxt = filled_head_r;
    filled_tail_nxt = filled_tail_r;
    filled_cnt_nxt  = filled_cnt_r;
    open_nxt        = open_r;
    res_nxt         = res_r;
    outv_nxt        = outv_r && !out_ready;
    lw_en = 1'b0; lw_a = '0; lw_d = '0;
    lw2_en = 1'b0; lw2_a = '0; lw2_d = '0;
    fw_en = 1'b0; fw_a = '0; fw_d = '0;
    vw_en = 1'b0; vw_a = '0;
    add_new    = (open_r == NONE);
    v          = add_new ? free_head_r[VW-1:0] : open_r[VW-1:0];
    fill_cur   = add_new ? '0 : fill_rd_r;
    fill_new   = fill_cur + FW'(1);
    rd_vec_ok  = ({1'b0, cur_r.read_vector} < 10'(NUM_VECTORS));
    rd_slot_ok = ({1'b0, cur_r.read_slot} < 9'(SLOTS_PER_VECTOR));
    unique case (state_r)
      S_INIT: begin
        lw_en = 1'b1; lw_a = init_r; lw_d = LW'(init_r) + LW'(1);
        fw_en = 1'b1; fw_a = init_r;
        if (init_r == VW'(NUM_VECTORS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_pop) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        outv_nxt  = 1'b1;
        res_nxt   = '0;
        case (cur_r.opcode)
          OP_ADD: begin
            if (add_new && free_head_r == NONE) begin
              res_nxt.status = ST_EMPTY;
            end else begin
              if (add_new) begin
                free_head_nxt = link_rd_r;
                lw_en = 1'b1; lw_a = v; lw_d = NONE;
                open_nxt = {1'b0, v};
              end
              vw_en = 1'b1; vw_a = {v, fill_cur[SW-1:0]};
              fw_en = 1'b1; fw_a = v; fw_d = fill_new;
              if (fill_new == FW'(SLOTS_PER_VECTOR)) begin
                if (filled_cnt_r == '0 || filled_tail_r == NONE) begin
                  filled_head_nxt = {1'b0, v};
                end else begin
                  lw2_en = 1'b1; lw2_a = filled_tail_r[VW-1:0]; lw2_d = {1'b0, v};
                end
                filled_tail_nxt = {1'b0, v};
                if (filled_cnt_r != NONE) filled_cnt_nxt = filled_cnt_r + LW'(1);
                open_nxt = NONE;
              end
            end
          end
          OP_TAKE_FULL: begin
            if (filled_cnt_r == '0) begin
              res_nxt.status = ST_NOTHING;
            end else begin
              res_nxt.batch_head  = 9'(filled_head_r);
              res_nxt.batch_tail  = 9'(filled_tail_r);
              res_nxt.batch_count = 10'(filled_cnt_r);
              filled_head_nxt = NONE;
              filled_tail_nxt = NONE;
              filled_cnt_nxt  = '0;
            end
          end
          OP_TAKE_OPEN: begin
            if (open_r == NONE) begin
              res_nxt.status = ST_NOTHING;
            end else begin
              res_nxt.batch_head  = 9'(open_r);
              res_nxt.batch_tail  = 9'(open_r);
              res_nxt.batch_count = 10'd1;
              open_nxt = NONE;
            end
          end
          OP_FREE: begin
            if (cur_r.chain_count == 10'd1 &&
                {1'b0, cur_r.chain_head} < 10'(NUM_VECTORS)) begin
              lw_en = 1'b1; lw_a = VW'(cur_r.chain_head); lw_d = free_head_r;
              free_head_nxt = LW'(cur_r.chain_head);
            end else if (cur_r.chain_count > 10'd1 &&
                {1'b0, cur_r.chain_head} < 10'(NUM_VECTORS) &&
                {1'b0, cur_r.chain_tail} < 10'(NUM_VECTORS)) begin
              lw_en = 1'b1; lw_a = VW'(cur_r.chain_tail); lw_d = free_head_r;
              free_head_nxt = LW'(cur_r.chain_head);
            end
          end
          OP_READ: begin
            if (rd_vec_ok) begin
              if (rd_slot_ok) res_nxt.slot_value = 32'(val_rd_r);
              res_nxt.next_link  = 10'(link_rd_r);
              res_nxt.fill_count = 9'(fill_rd_r);
            end else begin
              res_nxt.next_link = 10'(NONE);
            end
          end
          default: ;
        endcase
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_INIT;
      init_r        <= '0;
      free_head_r   <= '0;
      filled_head_r <= NONE;
      filled_tail_r <= NONE;
      filled_cnt_r  <= '0;
      open_r        <= NONE;
      outv_r        <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      init_r        <= init_r + VW'(1);
      free_head_r   <= free_head_nxt;
      filled_head_r <= filled_head_nxt;
      filled_tail_r <= filled_tail_nxt;
      filled_cnt_r  <= filled_cnt_nxt;
      open_r        <= open_nxt;
      outv_r        <= outv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (q_pop) cur_r <= q_data;
  end

  assign out_valid = outv_r;
  assign out_data  = res_r;

  a_exec_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == S_EXEC) else $error("pop without execute");
  a_no_pop_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INIT |-> !q_pop) else $error("item taken during init");
  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |=> out_valid) else $error("execute without result");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_cnt_r <= NONE) else $error("filled count overflow");

endmodule
`default_nettype wire

### hdl/batch_vector_pool_unit.sv
// ----------------------------------------------------------------------------
// batch_vector_pool_unit
// Pool of fixed-size vectors on a free list, batched into filled chains.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in_     | input     | bvp_pkg::in_item_t  (opcode, value, chain and read fields)
//  out_    | output    | bvp_pkg::out_item_t (status, batch, read fields)
//
//  In the back end each item gets a synchronous read of the link, fill and
//  value memories at pop, then an execute state that writes them back.
//  After reset an init sweep over all NUM_VECTORS entries loads the link and fill
//  tables; items queue at the input (two deep) but do not execute until then.
//  A stalled result register holds the back end; the input queue still fills.
// ----------------------------------------------------------------------------
`default_nettype none
module batch_vector_pool_unit #(
  parameter int unsigned NUM_VECTORS      = bvp_pkg::NUM_VECTORS_DEF,
  parameter int unsigned SLOTS_PER_VECTOR = bvp_pkg::SLOTS_PER_VECTOR_DEF,
  parameter int unsigned VALUE_WIDTH      = bvp_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bvp_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bvp_pkg::out_item_t      out_data
);
  import bvp_pkg::*;

  logic     q_valid, q_pop;
  in_item_t q_data;

  // front: accept and buffer items
  bvp_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_valid, .q_pop, .q_data
  );

  // back: table access and result register
  bvp_back #(
    .NUM_VECTORS(NUM_VECTORS), .SLOTS_PER_VECTOR(SLOTS_PER_VECTOR),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_data,
    .out_valid, .out_ready, .out_data
  );

endmodule
`default_nettype wire
